/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// signal holds its value in the cycle after cond
`define CHK_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

/* hw/rtl/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } t_err_code;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIV,
        BK_EMIT
    } t_bk_state;

    typedef struct packed {
        t_op_kind   kind;
        logic [3:0] digit;
        logic       last;
    } t_q_item;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              has_value;
        t_err_code         error;
    } t_res;

endpackage

/* hw/rtl/pfe_front.sv */
// ----------------------------------------------------------------------------
// pfe_front
// Accepts characters and classifies them into queue entries
// ----------------------------------------------------------------------------
module pfe_front (
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [7:0]       i_symbol,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_push,
    output pfe_pkg::t_q_item o_item
);
    import pfe_pkg::*;

    logic [7:0] w_offset;

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;
    assign w_offset = i_symbol - CHAR_ZERO;

    always_comb begin
        o_item.digit = w_offset[3:0];
        o_item.last  = i_last;
        if (i_symbol inside {[CHAR_ZERO:CHAR_NINE]}) begin
            o_item.kind = OP_DIGIT;
        end else begin
            case (i_symbol)
                CHAR_PLUS:  o_item.kind = OP_ADD;
                CHAR_MINUS: o_item.kind = OP_SUB;
                CHAR_STAR:  o_item.kind = OP_MUL;
                CHAR_SLASH: o_item.kind = OP_DIV;
                default:    o_item.kind = OP_NONE;
            endcase
        end
    end

endmodule

/* hw/rtl/pfe_queue.sv */
// ----------------------------------------------------------------------------
// pfe_queue
// Short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module pfe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfe_pkg::t_q_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output pfe_pkg::t_q_item o_item,
    output logic             o_empty
);
    import pfe_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_q_item       r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_fill;

    assign o_full  = (r_fill == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (AW+1)'(1);
                2'b01:   r_fill <= r_fill - (AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* hw/rtl/pfe_divider.sv */
// ----------------------------------------------------------------------------
// pfe_divider
// Signed 32-bit divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfe_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_div_req i_req,
    output pfe_pkg::t_div_rsp o_rsp
);
    import pfe_pkg::*;

    localparam int SW = $clog2(DIV_STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_steps;
    logic              r_neg;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quot;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic              w_bit;

    assign w_mag_a = i_req.dividend[DATA_W-1] ? (DATA_W'(0) - i_req.dividend)
                                              : i_req.dividend;
    assign w_mag_b = i_req.divisor[DATA_W-1] ? (DATA_W'(0) - i_req.divisor)
                                             : i_req.divisor;
    assign w_shift = {r_rem, r_quot[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_bit   = !w_diff[DATA_W];

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (DATA_W'(0) - r_quot) : r_quot;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= w_mag_a;
            r_dvs  <= w_mag_b;
            r_neg  <= i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem  <= w_bit ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_quot <= {r_quot[DATA_W-2:0], w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= r_busy && (r_steps == SW'(1));
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= SW'(DIV_STEPS);
            end else if (r_busy) begin
                r_steps <= r_steps - SW'(1);
                if (r_steps == SW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/pfe_back.sv */
// ----------------------------------------------------------------------------
// pfe_back
// Operand stack, operator execution and result register
// ----------------------------------------------------------------------------
module pfe_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  pfe_pkg::t_q_item  i_item,
    output logic              o_pop,
    output pfe_pkg::t_div_req o_div_req,
    input  pfe_pkg::t_div_rsp i_div_rsp,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    output pfe_pkg::t_res     o_res
);
    import pfe_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    // top of stack lives in r_top, the entries below it in r_stack
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];

    t_bk_state         r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_err_code         r_err, n_err;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_below;
    t_op_kind          r_kind, n_kind;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              w_wr_en;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;
    logic [DATA_W-1:0] w_prod;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    // only the low word of the product is kept
    assign w_prod   = r_below * r_top;

    assign o_m_valid = r_out_valid;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_cnt_m1[IW-1:0]] <= r_top;
        end
        r_below <= r_stack[w_cnt_m2[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_kind <= n_kind;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        logic w_finish;

        n_state           = r_state;
        n_count           = r_count;
        n_err             = r_err;
        n_top             = r_top;
        n_kind            = r_kind;
        n_last            = r_last;
        n_out             = r_out;
        n_out_valid       = r_out_valid && !i_m_ready;
        o_pop             = 1'b0;
        w_wr_en           = 1'b0;
        w_finish          = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_below;
        o_div_req.divisor  = r_top;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_kind  = i_item.kind;
                    n_last  = i_item.last;
                    n_state = i_item.last ? BK_EMIT : BK_IDLE;
                    case (i_item.kind)
                        OP_DIGIT: begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                            end else begin
                                w_wr_en = (r_count != '0);
                                n_top   = DATA_W'(i_item.digit);
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_count < CW'(2)) begin
                                if (r_err == ERR_NONE) n_err = ERR_UNDERFLOW;
                            end else begin
                                // below operand is read out during this cycle
                                n_state = BK_EXEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_EXEC: begin
                w_finish = 1'b1;
                case (r_kind)
                    OP_ADD: n_top = r_below + r_top;
                    OP_SUB: n_top = r_below - r_top;
                    OP_MUL: n_top = w_prod;
                    default: begin
                        if (r_top == '0) begin
                            if (r_err == ERR_NONE) n_err = ERR_DIVZERO;
                            n_top = '0;
                        end else begin
                            o_div_req.start = 1'b1;
                            w_finish        = 1'b0;
                            n_state         = BK_DIV;
                        end
                    end
                endcase
            end
            BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_top    = i_div_rsp.quotient;
                    w_finish = 1'b1;
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.has_value = (r_count != '0);
                    n_out.value     = (r_count != '0) ? r_top : '0;
                    n_out.error     = r_err;
                    n_count         = '0;
                    n_err           = ERR_NONE;
                    n_state         = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase

        if (w_finish) begin
            n_count = r_count - CW'(1);
            n_state = r_last ? BK_EMIT : BK_IDLE;
        end
    end

endmodule

/* hw/rtl/postfix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Reverse Polish expression evaluator over a character stream
// ----------------------------------------------------------------------------
// Characters enter on the s_axis channel, one per request: tdata carries the
// ASCII code, tlast marks the last character of an expression. Digits push
// 0..9, + - * / combine the two top entries (below op top), all else is
// ignored. Each expression gives one request on m_axis: tdata is the top of
// the stack, tuser bit 0 says the stack was nonempty, bits 2:1 the first
// error (underflow, overflow, divide by zero).
// A four-entry queue decouples the input from the execution unit. In the
// execution unit a digit or an ignored code is handled in the idle state;
// + - * pass on to the execute state, / goes on to the bit-serial divider
// (32 steps). The result passes the emit state into its output register.
// Reset clears the stack count, the error and the queue, synchronously. When
// m_axis_tready is low the result holds in its register, the unit keeps
// working until the next result, then the queue fills and s_axis_tready
// drops.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [0] has_value, [2:1] error
);
    import pfe_pkg::*;

    t_q_item  w_in_item;
    t_q_item  w_q_item;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_res     w_res;

    pfe_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_symbol (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    pfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_empty (w_empty)
    );

    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_res     (w_res)
    );

    pfe_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign m_axis_tdata = w_res.value;
    assign m_axis_tuser = {w_res.error, w_res.has_value};

endmodule

/* hw/rtl/pfe_checker.sv */
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the postfix expression evaluator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // expressions taken in whose result has not been delivered yet
    logic [7:0] r_pending;
    logic       w_in_end;
    logic       w_out_take;

    assign w_in_end   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign w_out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({w_in_end, w_out_take})
                2'b10:   r_pending <= r_pending + 8'd1;
                2'b01:   r_pending <= r_pending - 8'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    `CHK_HOLD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, {m_axis_tvalid, m_axis_tdata, m_axis_tuser}, "result changed while stalled")
    `CHK_ASSERT(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0, "empty stack result not zero")
    `CHK_ASSERT(a_no_spurious, i_clk, i_rst_n, m_axis_tvalid |-> r_pending != 8'd0, "result without a finished expression")
    `CHK_ASSERT(a_reset_idle, i_clk, i_rst_n, $past(!i_rst_n) |-> !m_axis_tvalid, "result valid right after reset")

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (.*);
